### rtl/wmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wmc_pkg: shared constants and types of the warp match checker
// Widths, command codes and table geometry.
// ----------------------------------------------------------------------------
package wmc_pkg;

  localparam int MAX_IMAGE_WIDTH  = 512;
  localparam int MAX_IMAGE_HEIGHT = 512;
  localparam int COUNT_BITS       = 32;
  localparam int COL_BITS         = $clog2(MAX_IMAGE_WIDTH);
  localparam int ROW_BITS         = $clog2(MAX_IMAGE_HEIGHT);
  localparam int ADDR_BITS        = COL_BITS + ROW_BITS;
  localparam int CFG_IDX_BITS     = 3;
  localparam int CFG_DATA_BITS    = 16;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SPARSE = 2'd1,
    CMD_DENSE  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_MAP_WA  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAP_HA  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAP_WB  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAP_HB  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMG_W   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMG_H   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH  = 3'd6;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [8:0]         warp_row;
    logic [8:0]         warp_col;
    logic signed [19:0] warp_x;
    logic signed [19:0] warp_y;
    logic               warp_finite;
    logic [15:0]        point_a_x;
    logic [15:0]        point_a_y;
    logic [15:0]        point_b_x;
    logic [15:0]        point_b_y;
    logic               indices_valid;
  } in_item_t;

  typedef struct packed {
    logic        counted;
    logic        match_correct;
    logic [31:0] sparse_total_count;
    logic [31:0] sparse_correct_count;
    logic [31:0] dense_total_count;
    logic [31:0] dense_correct_count;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
  } cfg_item_t;

endpackage

`default_nettype wire

### rtl/wmc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wmc_if: valid/ready channel
// Carries one payload of the given type between a source and a sink.
// ----------------------------------------------------------------------------
interface wmc_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/wmc_scaler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wmc_scaler: feature-map to pixel scaling unit
// Computes min(W-1, floor((P+8)*W/(16*M))) by restoring division, one
// quotient bit a cycle, four coordinates in parallel lanes.
// ----------------------------------------------------------------------------
module wmc_scaler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] p [4],
  input  wire logic [12:0] m [4],
  input  wire logic [9:0]  img [4],
  output logic             done,
  output logic [9:0]       pix [4]
);
  import wmc_pkg::*;

  // Dividend up to 65543*512 < 2^26; quotient fits in 26 bits.
  localparam int NUM_BITS = 26;
  localparam int DEN_BITS = 17;
  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] num [4];
  logic [NUM_BITS-1:0] quo [4];
  logic [DEN_BITS:0]   rem [4];
  logic [DEN_BITS-1:0] den [4];
  logic [9:0]          lim [4];
  logic [CNT_BITS-1:0] cnt;
  logic                busy;

  // Run the shared step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == CNT_BITS'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(NUM_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // One quotient bit per lane per cycle
  for (genvar i = 0; i < 4; i++) begin : g_lane
    logic [DEN_BITS:0] trial;
    logic [12:0]       meff;
    assign meff  = (m[i] == '0) ? 13'd1 : m[i];
    assign trial = {rem[i][DEN_BITS-1:0], num[i][NUM_BITS-1]};

    always_ff @(posedge clk) begin
      if (start) begin
        num[i] <= NUM_BITS'((27'(p[i]) + 27'd8) * 27'(img[i]));
        den[i] <= {meff, 4'b0};
        lim[i] <= img[i] - 10'd1;
        rem[i] <= '0;
        quo[i] <= '0;
      end else if (busy) begin
        num[i] <= {num[i][NUM_BITS-2:0], 1'b0};
        if (trial >= {1'b0, den[i]}) begin
          rem[i] <= trial - {1'b0, den[i]};
          quo[i] <= {quo[i][NUM_BITS-2:0], 1'b1};
        end else begin
          rem[i] <= trial;
          quo[i] <= {quo[i][NUM_BITS-2:0], 1'b0};
        end
      end
    end

    assign pix[i] = (quo[i] > NUM_BITS'(lim[i])) ? lim[i] : quo[i][9:0];
  end

endmodule

`default_nettype wire

### rtl/warp_match_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// A load, skipped or unused item goes from the idle state straight to the
//   result stage; a tallied match first runs the 26-step bit-serial scaling
//   divide, then the warp memory read, distance, square and compare stages.
// Only one item at a time is taken; a waiting result holds the sequencer in
//   the result stage. Reset zeroes the counters and returns config to
//   defaults; the warp memory is not cleared.
// ----------------------------------------------------------------------------
// warp_match_checker: ground-truth match checker
// Scales match points, loads and reads the warp table and tallies hits in counters.
// ----------------------------------------------------------------------------
module warp_match_checker (
  input  wire logic clk,
  input  wire logic rst,
  wmc_if.sink       in_ch,
  wmc_if.sink       cfg_ch,
  wmc_if.source     out_ch
);
  import wmc_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCALE = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_DIST  = 7'b0001000,
    ST_SQR   = 7'b0010000,
    ST_CMP   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t      state;
  in_item_t    item;
  logic [12:0] map_wa, map_ha, map_wb, map_hb;
  logic [9:0]  img_w, img_h;
  logic [15:0] thresh;
  logic [COUNT_BITS-1:0] s_tot, s_cor, d_tot, d_cor;

  logic [40:0] warp_mem [MAX_IMAGE_WIDTH*MAX_IMAGE_HEIGHT];
  logic [40:0] rd_data;
  logic        wr_en;
  logic [ADDR_BITS-1:0] wr_addr, rd_addr;

  logic        sc_start, sc_done;
  logic        sc_busy_q;
  logic [15:0] sc_p [4];
  logic [12:0] sc_m [4];
  logic [9:0]  sc_img [4];
  logic [9:0]  sc_pix [4];
  logic [9:0]  xb, yb;
  logic [9:0]  img_w_eff, img_h_eff;

  logic [21:0] dx, dy;
  logic [43:0] dx2, dy2;
  logic [31:0] t2;
  logic        correct;
  logic        res_counted, res_correct;
  logic        in_fire;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state == ST_IDLE);
  assign cfg_ch.ready = (state == ST_IDLE);

  // Effective image sizes: zero as one, saturate to the table size
  always_comb begin
    img_w_eff = (img_w == '0) ? 10'd1 :
                (img_w > 10'(MAX_IMAGE_WIDTH)) ? 10'(MAX_IMAGE_WIDTH) : img_w;
    img_h_eff = (img_h == '0) ? 10'd1 :
                (img_h > 10'(MAX_IMAGE_HEIGHT)) ? 10'(MAX_IMAGE_HEIGHT) : img_h;
  end

  assign sc_p   = '{item.point_a_x, item.point_a_y, item.point_b_x, item.point_b_y};
  assign sc_m   = '{map_wa, map_ha, map_wb, map_hb};
  assign sc_img = '{img_w_eff, img_h_eff, img_w_eff, img_h_eff};
  assign sc_start = (state == ST_SCALE) && !sc_busy_q;

  wmc_scaler u_scaler (
    .clk   (clk),
    .rst   (rst),
    .start (sc_start),
    .p     (sc_p),
    .m     (sc_m),
    .img   (sc_img),
    .done  (sc_done),
    .pix   (sc_pix)
  );

  // Warp memory: load writes, match reads through a registered read port
  assign wr_en   = in_fire && (in_ch.data.cmd == CMD_LOAD);
  assign wr_addr = {in_ch.data.warp_row, in_ch.data.warp_col};
  assign rd_addr = {sc_pix[1][ROW_BITS-1:0], sc_pix[0][COL_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      warp_mem[wr_addr] <= {in_ch.data.warp_finite, in_ch.data.warp_y,
                            in_ch.data.warp_x};
    end
    rd_data <= warp_mem[rd_addr];
  end

  // Squared distances, registered after the multipliers
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      xb <= sc_pix[2];
      yb <= sc_pix[3];
    end
    if (state == ST_DIST) begin
      dx  <= 22'({xb, 6'b0}) - 22'(signed'(rd_data[19:0]));
      dy  <= 22'({yb, 6'b0}) - 22'(signed'(rd_data[39:20]));
      t2  <= 32'(thresh) * 32'(thresh);
    end
    if (state == ST_SQR) begin
      dx2 <= 44'(signed'(dx)) * 44'(signed'(dx));
      dy2 <= 44'(signed'(dy)) * 44'(signed'(dy));
    end
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_wa <= 13'd1; map_ha <= 13'd1; map_wb <= 13'd1; map_hb <= 13'd1;
      img_w  <= 10'd512; img_h <= 10'd512; thresh <= 16'd192;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.data.index)
        REG_MAP_WA: map_wa <= cfg_ch.data.data[12:0];
        REG_MAP_HA: map_ha <= cfg_ch.data.data[12:0];
        REG_MAP_WB: map_wb <= cfg_ch.data.data[12:0];
        REG_MAP_HB: map_hb <= cfg_ch.data.data[12:0];
        REG_IMG_W:  img_w  <= cfg_ch.data.data[9:0];
        REG_IMG_H:  img_h  <= cfg_ch.data.data[9:0];
        REG_THRESH: thresh <= cfg_ch.data.data;
        default: ;
      endcase
    end
  end

  // Sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (in_fire) item <= in_ch.data;
    if (rst) begin
      state        <= ST_IDLE;
      sc_busy_q    <= 1'b0;
      s_tot <= '0; s_cor <= '0; d_tot <= '0; d_cor <= '0;
      out_ch.valid <= 1'b0;
      correct      <= 1'b0;
      res_counted  <= 1'b0;
      res_correct  <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != ST_OUT) out_ch.valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_ch.data.cmd == CMD_DENSE ||
                (in_ch.data.cmd == CMD_SPARSE && in_ch.data.indices_valid)) begin
              state <= ST_SCALE;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_SCALE: begin
          if (sc_done) begin
            sc_busy_q <= 1'b0;
            state     <= ST_READ;
          end else begin
            sc_busy_q <= 1'b1;
          end
        end
        ST_READ: state <= ST_DIST;
        ST_DIST: state <= ST_SQR;
        ST_SQR:  state <= ST_CMP;
        ST_CMP: begin
          correct <= rd_data[40] && ({1'b0, dx2} + {1'b0, dy2} <= 45'(t2));
          state   <= ST_OUT;
        end
        ST_OUT: begin
          // Hold until the previous result has left
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            if (item.cmd == CMD_SPARSE && item.indices_valid) begin
              res_counted <= 1'b1;
              res_correct <= correct;
              if (s_tot != '1) s_tot <= s_tot + 1'b1;
              if (correct && s_cor != '1) s_cor <= s_cor + 1'b1;
            end else if (item.cmd == CMD_DENSE) begin
              res_counted <= 1'b1;
              res_correct <= correct;
              if (d_tot != '1) d_tot <= d_tot + 1'b1;
              if (correct && d_cor != '1) d_cor <= d_cor + 1'b1;
            end else begin
              res_counted <= 1'b0;
              res_correct <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.data = '{counted:              res_counted,
                         match_correct:        res_correct,
                         sparse_total_count:   32'(s_tot),
                         sparse_correct_count: 32'(s_cor),
                         dense_total_count:    32'(d_tot),
                         dense_correct_count:  32'(d_cor)};

  // Checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> state == ST_IDLE) else $error("item accepted while busy");
  a_out_after_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == ST_OUT) else $error("stray result");
  a_tot_ge_cor: assert property (@(posedge clk) disable iff (rst)
    s_tot >= s_cor && d_tot >= d_cor) else $error("correct exceeds total");

endmodule

`default_nettype wire
